### design/cone_annulus_energy_isolation_defines.svh
// ----------------------------------------------------------------------------
// cone annulus energy isolation assertion macros
// shared property forms for the checker files
// ----------------------------------------------------------------------------
`ifndef CONE_ANNULUS_ENERGY_ISOLATION_DEFINES_SVH
`define CONE_ANNULUS_ENERGY_ISOLATION_DEFINES_SVH

// same-cycle implication
`define CAI_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cai assertion failed");

// next-cycle implication
`define CAI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cai assertion failed");

`endif

### design/cai_pkg.sv
// ----------------------------------------------------------------------------
// cai_pkg
// widths, register indexes, reset values and shared types of the isolation sum
// ----------------------------------------------------------------------------
package cai_pkg;

   localparam int SUM_WIDTH       = 32;
   localparam int OUT_WIDTH       = 32;
   localparam int ET_WIDTH        = 16;
   localparam int RADIUS_WIDTH    = 23;
   localparam int ETA_WIDTH       = 14;
   localparam int PHI_WIDTH       = 13;
   localparam int PT_WIDTH        = 16;
   localparam int Q_FRAC_BITS     = 16;

   localparam int DETA_WIDTH      = ETA_WIDTH + 1;
   localparam int DPHI_WIDTH      = PHI_WIDTH + 1;
   localparam int DETA_SQ_WIDTH   = 2 * ETA_WIDTH;
   localparam int DPHI_SQ_WIDTH   = 2 * PHI_WIDTH;
   localparam int DIST_WIDTH      = DETA_SQ_WIDTH + 1;

   localparam int DIV_WIDTH       = SUM_WIDTH + Q_FRAC_BITS;
   localparam int DIV_CNT_WIDTH   = $clog2(DIV_WIDTH);

   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_DATA_WIDTH  = 23;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OUTER_RADIUS_SQ = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INNER_RADIUS_SQ = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RELATIVE_MODE   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ELECTRON_ETA    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ELECTRON_PHI    = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ELECTRON_PT     = 3'd5;

   // pi and two pi in 1/1024 rad
   localparam logic signed [DPHI_WIDTH-1:0] PI_LSB     = 14'sd3217;
   localparam logic signed [DPHI_WIDTH-1:0] NEG_PI_LSB = -14'sd3217;
   localparam logic signed [DPHI_WIDTH-1:0] TWO_PI_LSB = 14'sd6434;

   typedef struct packed {
      logic        [RADIUS_WIDTH-1:0] outer_radius_sq;
      logic        [RADIUS_WIDTH-1:0] inner_radius_sq;
      logic                           relative_mode;
      logic signed [ETA_WIDTH-1:0]    electron_eta;
      logic signed [PHI_WIDTH-1:0]    electron_phi;
      logic        [PT_WIDTH-1:0]     electron_pt;
   } cfg_type;

   // 0.4 squared for the outer radius, zero inner radius, relative mode
   localparam cfg_type CFG_RESET = '{
      outer_radius_sq: 23'd167772,
      inner_radius_sq: 23'd0,
      relative_mode:   1'b1,
      electron_eta:    14'sd0,
      electron_phi:    13'sd0,
      electron_pt:     16'd0
   };

   typedef struct packed {
      logic [ET_WIDTH-1:0] em_et;
      logic [ET_WIDTH-1:0] had_et;
      logic                last_tower;
   } tower_word_type;

   typedef struct packed {
      logic           valid;
      tower_word_type word;
   } queue_push_type;

   typedef struct packed {
      logic           valid;
      tower_word_type word;
   } queue_head_type;

endpackage

### design/cai_front.sv
// ----------------------------------------------------------------------------
// cai_front
// tower intake: eta-phi distance to the electron and annulus classification
// ----------------------------------------------------------------------------
module cai_front import cai_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  cfg_type                     cfg,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [ETA_WIDTH-1:0] req_tower_eta,
   input  logic signed [PHI_WIDTH-1:0] req_tower_phi,
   input  logic [ET_WIDTH-1:0]         req_em_et,
   input  logic [ET_WIDTH-1:0]         req_had_et,
   input  logic                        req_last_tower,
   input  logic [QUEUE_CNT_WIDTH-1:0]  queue_count,
   output queue_push_type              push
);

   logic                         a_valid_ff, a_valid_in;
   logic signed [DETA_WIDTH-1:0] a_deta_ff, a_deta_in;
   logic signed [DPHI_WIDTH-1:0] a_dphi_ff, a_dphi_in;
   tower_word_type               a_word_ff, a_word_in;

   logic                         b_valid_ff, b_valid_in;
   logic [DETA_SQ_WIDTH-1:0]     b_deta_sq_ff, b_deta_sq_in;
   logic [DPHI_SQ_WIDTH-1:0]     b_dphi_sq_ff, b_dphi_sq_in;
   tower_word_type               b_word_ff, b_word_in;

   logic [QUEUE_CNT_WIDTH:0]     occupancy;
   logic                         accept;
   logic signed [DPHI_WIDTH-1:0] dphi_raw;
   logic signed [2*DETA_WIDTH-1:0] deta_prod;
   logic signed [2*DPHI_WIDTH-1:0] dphi_prod;
   logic [DIST_WIDTH-1:0]        distance_sq;
   logic                         in_cone;

   // queue slots already spoken for by words in flight
   assign occupancy = {1'b0, queue_count}
                    + (QUEUE_CNT_WIDTH + 1)'(a_valid_ff)
                    + (QUEUE_CNT_WIDTH + 1)'(b_valid_ff);
   assign req_stall = reset || (occupancy >= (QUEUE_CNT_WIDTH + 1)'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   assign dphi_raw = {req_tower_phi[PHI_WIDTH-1], req_tower_phi}
                   - {cfg.electron_phi[PHI_WIDTH-1], cfg.electron_phi};

   always_comb begin
      a_valid_in       = accept;
      a_deta_in        = {req_tower_eta[ETA_WIDTH-1], req_tower_eta}
                       - {cfg.electron_eta[ETA_WIDTH-1], cfg.electron_eta};
      a_word_in.em_et      = req_em_et;
      a_word_in.had_et     = req_had_et;
      a_word_in.last_tower = req_last_tower;
      if (dphi_raw > PI_LSB) begin
         a_dphi_in = dphi_raw - TWO_PI_LSB;
      end else if (dphi_raw < NEG_PI_LSB) begin
         a_dphi_in = dphi_raw + TWO_PI_LSB;
      end else begin
         a_dphi_in = dphi_raw;
      end
   end

   assign deta_prod = a_deta_ff * a_deta_ff;
   assign dphi_prod = a_dphi_ff * a_dphi_ff;

   always_comb begin
      b_valid_in   = a_valid_ff;
      b_deta_sq_in = deta_prod[DETA_SQ_WIDTH-1:0];
      b_dphi_sq_in = dphi_prod[DPHI_SQ_WIDTH-1:0];
      b_word_in    = a_word_ff;
   end

   assign distance_sq = DIST_WIDTH'(b_deta_sq_ff) + DIST_WIDTH'(b_dphi_sq_ff);
   assign in_cone     = (distance_sq < DIST_WIDTH'(cfg.outer_radius_sq))
                     && (distance_sq > DIST_WIDTH'(cfg.inner_radius_sq));

   always_comb begin
      push.valid           = b_valid_ff;
      push.word.em_et      = in_cone ? b_word_ff.em_et : '0;
      push.word.had_et     = in_cone ? b_word_ff.had_et : '0;
      push.word.last_tower = b_word_ff.last_tower;
   end

   always_ff @(posedge clock) begin
      a_deta_ff    <= a_deta_in;
      a_dphi_ff    <= a_dphi_in;
      a_word_ff    <= a_word_in;
      b_deta_sq_ff <= b_deta_sq_in;
      b_dphi_sq_ff <= b_dphi_sq_in;
      b_word_ff    <= b_word_in;
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

endmodule

### design/cai_queue.sv
// ----------------------------------------------------------------------------
// cai_queue
// short queue of classified tower words between intake and accumulator
// ----------------------------------------------------------------------------
module cai_queue import cai_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  queue_push_type             push,
   input  logic                       pop,
   output queue_head_type             head,
   output logic [QUEUE_CNT_WIDTH-1:0] count
);

   tower_word_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1))
                   ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1))
                   ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push.valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push.valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.word  = slot_ff[rd_ptr_ff];
   assign count      = count_ff;

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slot_ff[wr_ptr_ff] <= push.word;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### design/cai_back.sv
// ----------------------------------------------------------------------------
// cai_back
// saturating accumulation, shift-subtract pT division and result register
// ----------------------------------------------------------------------------
module cai_back import cai_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  queue_head_type       head,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [OUT_WIDTH-1:0] rsp_em_isolation,
   output logic [OUT_WIDTH-1:0] rsp_had_isolation,
   output logic                 rsp_momentum_missing
);

   typedef enum logic {ST_ACCUM, ST_DIVIDE} state_type;

   typedef struct packed {
      logic [DIV_WIDTH-1:0] num;
      logic [PT_WIDTH-1:0]  rem;
   } div_step_type;

   function automatic logic [SUM_WIDTH-1:0] sat_add(
      input logic [SUM_WIDTH-1:0] sum,
      input logic [ET_WIDTH-1:0]  et
   );
      logic [SUM_WIDTH:0] total;
      total = {1'b0, sum} + (SUM_WIDTH + 1)'(et);
      return total[SUM_WIDTH] ? '1 : total[SUM_WIDTH-1:0];
   endfunction

   function automatic logic [OUT_WIDTH-1:0] sat_out(input logic [DIV_WIDTH-1:0] v);
      return (|v[DIV_WIDTH-1:OUT_WIDTH]) ? '1 : v[OUT_WIDTH-1:0];
   endfunction

   // one quotient bit per call, quotient shifts in where the dividend leaves
   function automatic div_step_type div_step(
      input logic [DIV_WIDTH-1:0] num,
      input logic [PT_WIDTH-1:0]  rem,
      input logic [PT_WIDTH-1:0]  divisor
   );
      logic [PT_WIDTH:0] trial;
      logic              fits;
      div_step_type      r;
      trial = {rem, num[DIV_WIDTH-1]};
      fits  = (trial >= {1'b0, divisor});
      r.rem = fits ? PT_WIDTH'(trial - {1'b0, divisor}) : trial[PT_WIDTH-1:0];
      r.num = {num[DIV_WIDTH-2:0], fits};
      return r;
   endfunction

   state_type              state_ff, state_in;
   logic [SUM_WIDTH-1:0]   em_sum_ff, em_sum_in;
   logic [SUM_WIDTH-1:0]   had_sum_ff, had_sum_in;
   logic [DIV_WIDTH-1:0]   em_num_ff, em_num_in;
   logic [DIV_WIDTH-1:0]   had_num_ff, had_num_in;
   logic [PT_WIDTH-1:0]    em_rem_ff, em_rem_in;
   logic [PT_WIDTH-1:0]    had_rem_ff, had_rem_in;
   logic [DIV_CNT_WIDTH-1:0] div_cnt_ff, div_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [OUT_WIDTH-1:0]   rsp_em_ff, rsp_em_in;
   logic [OUT_WIDTH-1:0]   rsp_had_ff, rsp_had_in;
   logic                   rsp_missing_ff, rsp_missing_in;

   logic                   out_free;
   logic                   missing;
   logic [SUM_WIDTH-1:0]   em_next, had_next;
   div_step_type           em_step, had_step;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign missing  = cfg.relative_mode && (cfg.electron_pt == '0);
   assign em_next  = sat_add(em_sum_ff, head.word.em_et);
   assign had_next = sat_add(had_sum_ff, head.word.had_et);
   assign em_step  = div_step(em_num_ff, em_rem_ff, cfg.electron_pt);
   assign had_step = div_step(had_num_ff, had_rem_ff, cfg.electron_pt);

   always_comb begin
      state_in       = state_ff;
      em_sum_in      = em_sum_ff;
      had_sum_in     = had_sum_ff;
      em_num_in      = em_num_ff;
      had_num_in     = had_num_ff;
      em_rem_in      = em_rem_ff;
      had_rem_in     = had_rem_ff;
      div_cnt_in     = div_cnt_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_em_in      = rsp_em_ff;
      rsp_had_in     = rsp_had_ff;
      rsp_missing_in = rsp_missing_ff;
      pop            = 1'b0;
      case (state_ff)
         ST_ACCUM: begin
            if (head.valid && (!head.word.last_tower || out_free)) begin
               pop = 1'b1;
               if (!head.word.last_tower) begin
                  em_sum_in  = em_next;
                  had_sum_in = had_next;
               end else begin
                  em_sum_in  = '0;
                  had_sum_in = '0;
                  if (cfg.relative_mode && !missing) begin
                     state_in   = ST_DIVIDE;
                     em_num_in  = DIV_WIDTH'(em_next) << Q_FRAC_BITS;
                     had_num_in = DIV_WIDTH'(had_next) << Q_FRAC_BITS;
                     em_rem_in  = '0;
                     had_rem_in = '0;
                     div_cnt_in = '0;
                  end else begin
                     rsp_valid_in   = 1'b1;
                     rsp_em_in      = missing ? '1 : sat_out(DIV_WIDTH'(em_next));
                     rsp_had_in     = missing ? '1 : sat_out(DIV_WIDTH'(had_next));
                     rsp_missing_in = missing;
                  end
               end
            end
         end
         ST_DIVIDE: begin
            em_num_in  = em_step.num;
            had_num_in = had_step.num;
            em_rem_in  = em_step.rem;
            had_rem_in = had_step.rem;
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_CNT_WIDTH'(DIV_WIDTH - 1)) begin
               state_in       = ST_ACCUM;
               rsp_valid_in   = 1'b1;
               rsp_em_in      = sat_out(em_step.num);
               rsp_had_in     = sat_out(had_step.num);
               rsp_missing_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      em_num_ff      <= em_num_in;
      had_num_ff     <= had_num_in;
      em_rem_ff      <= em_rem_in;
      had_rem_ff     <= had_rem_in;
      div_cnt_ff     <= div_cnt_in;
      rsp_em_ff      <= rsp_em_in;
      rsp_had_ff     <= rsp_had_in;
      rsp_missing_ff <= rsp_missing_in;
      if (reset) begin
         state_ff     <= ST_ACCUM;
         em_sum_ff    <= '0;
         had_sum_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         em_sum_ff    <= em_sum_in;
         had_sum_ff   <= had_sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_em_isolation     = rsp_em_ff;
   assign rsp_had_isolation    = rsp_had_ff;
   assign rsp_momentum_missing = rsp_missing_ff;

endmodule

### design/cone_annulus_energy_isolation.sv
// ----------------------------------------------------------------------------
// cone_annulus_energy_isolation
// Each tower passes a two-stage distance pipeline (eta/phi differences with
// phi wrap, then squares and the annulus compare) into a four-word queue.
// Intake takes and the accumulator drains one tower per cycle unless intake
// stalls, the divider runs or a last tower waits on a held result. The last
// tower of a list in relative mode starts a shift-subtract divider by the
// electron pT over the sum width plus 16 fraction bits for both sums at once.
// Absolute mode and the missing-pT case give their result on the cycle after
// the last tower leaves the queue. Results wait in an output register while
// following towers are already accepted. The user must write configuration
// only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module cone_annulus_energy_isolation import cai_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]   csr_wdata,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [ETA_WIDTH-1:0] req_tower_eta,
   input  logic signed [PHI_WIDTH-1:0] req_tower_phi,
   input  logic [ET_WIDTH-1:0]         req_em_et,
   input  logic [ET_WIDTH-1:0]         req_had_et,
   input  logic                        req_last_tower,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [OUT_WIDTH-1:0]        rsp_em_isolation,
   output logic [OUT_WIDTH-1:0]        rsp_had_isolation,
   output logic                        rsp_momentum_missing
);

   cfg_type                      cfg_ff, cfg_in;
   queue_push_type               push;
   queue_head_type               head;
   logic                         pop;
   logic [QUEUE_CNT_WIDTH-1:0]   queue_count;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_OUTER_RADIUS_SQ: cfg_in.outer_radius_sq = csr_wdata[RADIUS_WIDTH-1:0];
            CSR_INNER_RADIUS_SQ: cfg_in.inner_radius_sq = csr_wdata[RADIUS_WIDTH-1:0];
            CSR_RELATIVE_MODE:   cfg_in.relative_mode   = csr_wdata[0];
            CSR_ELECTRON_ETA:    cfg_in.electron_eta    = csr_wdata[ETA_WIDTH-1:0];
            CSR_ELECTRON_PHI:    cfg_in.electron_phi    = csr_wdata[PHI_WIDTH-1:0];
            CSR_ELECTRON_PT:     cfg_in.electron_pt     = csr_wdata[PT_WIDTH-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cai_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_tower_eta  (req_tower_eta),
      .req_tower_phi  (req_tower_phi),
      .req_em_et      (req_em_et),
      .req_had_et     (req_had_et),
      .req_last_tower (req_last_tower),
      .queue_count    (queue_count),
      .push           (push)
   );

   cai_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .count (queue_count)
   );

   cai_back u_back (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg_ff),
      .head                 (head),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_em_isolation     (rsp_em_isolation),
      .rsp_had_isolation    (rsp_had_isolation),
      .rsp_momentum_missing (rsp_momentum_missing)
   );

endmodule

### design/cai_checker.sv
// ----------------------------------------------------------------------------
// cai_checker
// port-level checks of the isolation sum, bound to the top level
// ----------------------------------------------------------------------------
`include "cone_annulus_energy_isolation_defines.svh"

module cai_checker import cai_pkg::*; (
   input logic                        clock,
   input logic                        reset,
   input logic                        csr_wr_en,
   input logic [CSR_INDEX_WIDTH-1:0]  csr_index,
   input logic [CSR_DATA_WIDTH-1:0]   csr_wdata,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic signed [ETA_WIDTH-1:0] req_tower_eta,
   input logic signed [PHI_WIDTH-1:0] req_tower_phi,
   input logic [ET_WIDTH-1:0]         req_em_et,
   input logic [ET_WIDTH-1:0]         req_had_et,
   input logic                        req_last_tower,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [OUT_WIDTH-1:0]        rsp_em_isolation,
   input logic [OUT_WIDTH-1:0]        rsp_had_isolation,
   input logic                        rsp_momentum_missing
);

   // a held word keeps its payload
   `CAI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_em_isolation) && $stable(rsp_had_isolation) && $stable(rsp_momentum_missing))

   // missing pT reports worst isolation on both sums
   `CAI_ASSERT_IMPLY(a_missing_worst, clock, reset, rsp_valid && rsp_momentum_missing, (rsp_em_isolation == '1) && (rsp_had_isolation == '1))

   // leaving reset the block is empty and ready
   `CAI_ASSERT_IMPLY(a_reset_idle, clock, 1'b0, $past(reset) && !reset, !rsp_valid && !req_stall)

endmodule

bind cone_annulus_energy_isolation cai_checker u_cai_checker (.*);
